>>> rtl/core/zbh_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// zbh_pkg
// Shared types, constants and the key generator step of the board hasher.
// ============================================================================
package zbh_pkg;

    // board geometry
    localparam int BOARD_WORDS   = 7;
    localparam int WORD_CNT_W    = (BOARD_WORDS > 1) ? $clog2(BOARD_WORDS) : 1;
    localparam int WORD_W        = 64;
    localparam int BIT_W         = $clog2(WORD_W);
    localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(WORD_W - 1);
    localparam logic [WORD_CNT_W-1:0] WORD_LAST = WORD_CNT_W'(BOARD_WORDS - 1);

    // key generator
    localparam logic [63:0] KEY_SEED_RST = 64'h1234_5678_9ABC_DEF0;
    localparam logic [63:0] KEY_MULT     = 64'd2685821657736338717;
    localparam logic [31:0] KEY_MULT_LO  = KEY_MULT[31:0];
    localparam logic [31:0] KEY_MULT_HI  = KEY_MULT[63:32];
    localparam int          XS_SHIFT_A   = 12;
    localparam int          XS_SHIFT_B   = 25;
    localparam int          XS_SHIFT_C   = 27;

    // what the key of the current generator step belongs to
    typedef enum logic [2:0] {
        ROLE_RED     = 3'd0,
        ROLE_BLACK   = 3'd1,
        ROLE_TILE    = 3'd2,
        ROLE_PHASE0  = 3'd3,
        ROLE_PHASE1  = 3'd4,
        ROLE_PLAYER0 = 3'd5,
        ROLE_PLAYER1 = 3'd6
    } t_key_role;

    typedef struct packed {
        logic             capture;    // latch the input item
        logic             seed_load;  // restart generator, clear hash
        logic             step;       // one generator step, key into pipeline
        logic             load_out;   // copy hash into output register
        t_key_role        role;
        logic [BIT_W-1:0] bit_idx;
    } t_dp_cmd;

    typedef struct packed {
        logic pipe_busy;              // keys still in the multiply pipeline
    } t_dp_status;

    // xorshift state update
    function automatic logic [63:0] xs_next(input logic [63:0] s);
        logic [63:0] t;
        t = s ^ (s >> XS_SHIFT_A);
        t = t ^ (t << XS_SHIFT_B);
        t = t ^ (t >> XS_SHIFT_C);
        return t;
    endfunction

endpackage

>>> rtl/core/zbh_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// zbh_ctrl
// Sequencer: walks the key steps of a word and handles the item handshakes.
// ============================================================================
module zbh_ctrl
    import zbh_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_BITS  = 4'b0010,
        ST_EXTRA = 4'b0100,
        ST_DRAIN = 4'b1000
    } t_state;

    t_state                r_state,    n_state;
    logic [BIT_W-1:0]      r_bit,      n_bit;
    t_key_role             r_role,     n_role;
    logic [WORD_CNT_W-1:0] r_word_cnt, n_word_cnt;
    logic                  r_out_valid, n_out_valid;
    logic                  w_out_free;

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_bit       = r_bit;
        n_role      = r_role;
        n_word_cnt  = r_word_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd           = '0;
        o_cmd.role      = r_role;
        o_cmd.bit_idx   = r_bit;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture   = 1'b1;
                    o_cmd.seed_load = (r_word_cnt == '0);
                    n_bit   = '0;
                    n_role  = ROLE_RED;
                    n_state = ST_BITS;
                end
            end
            ST_BITS: begin
                o_cmd.step = 1'b1;
                case (r_role)
                    ROLE_RED:   n_role = ROLE_BLACK;
                    ROLE_BLACK: n_role = ROLE_TILE;
                    default: begin
                        n_role = ROLE_RED;
                        n_bit  = r_bit + 1'b1;
                        if (r_bit == BIT_LAST) begin
                            if (r_word_cnt == WORD_LAST) begin
                                n_word_cnt = '0;
                                n_role     = ROLE_PHASE0;
                                n_state    = ST_EXTRA;
                            end else begin
                                n_word_cnt = r_word_cnt + 1'b1;
                                n_state    = ST_IDLE;
                            end
                        end
                    end
                endcase
            end
            ST_EXTRA: begin
                o_cmd.step = 1'b1;
                case (r_role)
                    ROLE_PHASE0:  n_role = ROLE_PHASE1;
                    ROLE_PHASE1:  n_role = ROLE_PLAYER0;
                    ROLE_PLAYER0: n_role = ROLE_PLAYER1;
                    default:      n_state = ST_DRAIN;
                endcase
            end
            ST_DRAIN: begin
                if (!i_status.pipe_busy && w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_bit       <= '0;
            r_role      <= ROLE_RED;
            r_word_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bit       <= n_bit;
            r_role      <= n_role;
            r_word_cnt  <= n_word_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/core/zbh_datapath.sv
`timescale 1ns / 1ps
// ============================================================================
// zbh_datapath
// Key generator, split 64-bit multiply pipeline and hash accumulator.
// ============================================================================
module zbh_datapath
    import zbh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [63:0] i_cfg_data,
    input  logic [63:0] i_red_word,
    input  logic [63:0] i_black_word,
    input  logic [63:0] i_tile_word,
    input  logic        i_side_to_move,
    input  logic        i_move_phase,
    input  t_dp_cmd     i_cmd,
    output t_dp_status  o_status,
    output logic [63:0] o_board_hash
);

    logic [63:0] r_key_seed;
    logic [63:0] r_gen;
    logic [63:0] r_red, r_black, r_tile;
    logic        r_side, r_phase;

    // stage 1: generator output and whether its key is used
    logic [63:0] r_s1;
    logic        r_sel1, r_v1;
    // stage 2: partial products of the low 64 bits of s * mult
    logic [63:0] r_p_ll;
    logic [31:0] r_p_hl, r_p_lh;
    logic        r_sel2, r_v2;

    logic [63:0] r_acc;
    logic [63:0] r_hash_out;

    logic [63:0] w_s_next;
    logic        w_sel;
    logic [63:0] w_ll;
    logic [31:0] w_hl, w_lh;
    logic [63:0] w_key;

    assign w_s_next = xs_next(r_gen);

    always_comb begin
        case (i_cmd.role)
            ROLE_RED:     w_sel = r_red[i_cmd.bit_idx];
            ROLE_BLACK:   w_sel = r_black[i_cmd.bit_idx];
            ROLE_TILE:    w_sel = r_tile[i_cmd.bit_idx];
            ROLE_PHASE0:  w_sel = !r_phase;
            ROLE_PHASE1:  w_sel = r_phase;
            ROLE_PLAYER0: w_sel = !r_side;
            ROLE_PLAYER1: w_sel = r_side;
            default:      w_sel = 1'b0;
        endcase
    end

    assign w_ll  = {32'b0, r_s1[31:0]} * {32'b0, KEY_MULT_LO};
    assign w_hl  = r_s1[63:32] * KEY_MULT_LO;
    assign w_lh  = r_s1[31:0] * KEY_MULT_HI;
    assign w_key = {r_p_ll[63:32] + r_p_hl + r_p_lh, r_p_ll[31:0]};

    // control flags and the key seed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_seed <= KEY_SEED_RST;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_key_seed <= i_cfg_data;
            end
            r_v1 <= i_cmd.step;
            r_v2 <= r_v1;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_red   <= i_red_word;
            r_black <= i_black_word;
            r_tile  <= i_tile_word;
            r_side  <= i_side_to_move;
            r_phase <= i_move_phase;
        end
        if (i_cmd.seed_load) begin
            r_gen <= r_key_seed;
        end else if (i_cmd.step) begin
            r_gen <= w_s_next;
        end
        r_s1   <= w_s_next;
        r_sel1 <= w_sel;
        r_p_ll <= w_ll;
        r_p_hl <= w_hl;
        r_p_lh <= w_lh;
        r_sel2 <= r_sel1;
        if (i_cmd.seed_load) begin
            r_acc <= '0;
        end else if (r_v2 && r_sel2) begin
            r_acc <= r_acc ^ w_key;
        end
        if (i_cmd.load_out) begin
            r_hash_out <= r_acc;
        end
    end

    assign o_status.pipe_busy = r_v1 || r_v2;
    assign o_board_hash       = r_hash_out;

endmodule

>>> rtl/core/zobrist_board_hasher.sv
`timescale 1ns / 1ps
// ============================================================================
// zobrist_board_hasher
// Zobrist hash of a board that arrives as a sequence of 64-bit board words.
// ============================================================================
// A board is BOARD_WORDS items long; each item carries the red, black and tile
// occupancy bits of one 64-bit word, and the last item of a board also
// carries side_to_move and move_phase. Only the last item gives a result: the
// 64-bit board_hash. Keys come from an xorshift64* generator that restarts
// from key_seed at the first word of each board, and the generator makes one
// key per clock, so a word that is not the last of its board holds the input
// stalled until the red, black and tile keys of all its bits are drawn. The
// last word adds 4 generator steps for the phase and player keys and then
// waits for the multiply pipeline to empty before its hash lands in the
// output register (later only if an earlier hash is still stalled there).
// The output register lets the next board start while a hash waits to be
// taken. A key_seed write takes effect at the next board start.
// ============================================================================
module zobrist_board_hasher
    import zbh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write: key_seed
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [63:0] i_cfg_data,
    // input items
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [63:0] i_red_word,
    input  logic [63:0] i_black_word,
    input  logic [63:0] i_tile_word,
    input  logic        i_side_to_move,
    input  logic        i_move_phase,
    // result items
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_board_hash
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // the seed register takes a write in any cycle
    assign o_cfg_ready = 1'b1;

    // sequencer: bit and key-role counters, word count, output handshake
    zbh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // generator, key multiply pipeline and hash accumulation
    zbh_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_red_word     (i_red_word),
        .i_black_word   (i_black_word),
        .i_tile_word    (i_tile_word),
        .i_side_to_move (i_side_to_move),
        .i_move_phase   (i_move_phase),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_board_hash   (o_board_hash)
    );

endmodule

>>> rtl/core/zbh_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// zbh_checker
// Port-level checks of the board hasher, bound to the top level.
// ============================================================================
module zbh_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        o_in_stall,
    input  logic        o_out_valid,
    input  logic        i_out_stall,
    input  logic [63:0] o_board_hash
);

    // a stalled hash stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_board_hash))
        else $error("hash changed or dropped while stalled");

    // a taken item keeps the input stalled right after
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after an item was taken");

    // one key per clock: a word holds the input for its full bit walk
    a_word_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |-> ##192 o_in_stall)
        else $error("word walk ended early");

    // a hash only appears at the end of a word's processing
    a_hash_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("hash appeared while the block was idle");

endmodule

bind zobrist_board_hasher zbh_checker u_zbh_checker (.*);

>>> dv/tb_zobrist_board_hasher.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_zobrist_board_hasher
// Self-checking testbench for the Zobrist board hasher.
// ============================================================================
// Board words are queued by a stimulus process and offered by a clocked
// driver. Each accepted word runs through an in-bench model of the keyed
// hash: an xorshift64* key stream restarted from the seed at every board
// start, three keys per board bit and four trailing keys for phase and
// player. Every finished board pushes its expected hash. A clocked monitor
// pops one expected hash per accepted result and compares it. The seed
// register is rewritten between phases, sometimes while a board is half
// done, and the run covers zero, all-ones and random seeds. The result side
// stalls at random and once holds off long enough to back the block up.
// ============================================================================
module tb_zobrist_board_hasher;
    import zbh_pkg::*;

    // one board word as offered on the input channel
    typedef struct packed {
        logic [63:0] red;
        logic [63:0] black;
        logic [63:0] tile;
        logic        side;
        logic        phase;
    } t_board_word;

    // clock and reset
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;

    // configuration channel
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [63:0] i_cfg_data = '0;

    // input channel
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [63:0] i_red_word = '0;
    logic [63:0] i_black_word = '0;
    logic [63:0] i_tile_word = '0;
    logic        i_side_to_move = 1'b0;
    logic        i_move_phase = 1'b0;

    // result channel
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [63:0] o_board_hash;

    // stimulus and expectations
    t_board_word word_q[$];         // words waiting to be offered
    logic [63:0] pending_hashes[$]; // hashes predicted but not yet seen
    t_board_word offered;           // word currently on the input port
    int          send_gap = 0;
    int          stall_len = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    int          hashes_seen = 0;
    int          mismatches = 0;
    logic [63:0] want;
    int unsigned cyc = 0;

    // hasher model state
    logic [63:0] seed_m = KEY_SEED_RST;
    logic [63:0] gen_m = KEY_SEED_RST;
    logic [63:0] acc_m = '0;
    int          word_idx_m = 0;

    // window with no idling on either side
    wire quiet = (cyc >= 150000) && (cyc < 220000);

    zobrist_board_hasher u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_red_word     (i_red_word),
        .i_black_word   (i_black_word),
        .i_tile_word    (i_tile_word),
        .i_side_to_move (i_side_to_move),
        .i_move_phase   (i_move_phase),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_board_hash   (o_board_hash)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
    end

    // one step of the key stream: advance xorshift state, scramble by multiply
    function logic [63:0] draw_key();
        logic [63:0] s;
        s = gen_m;
        s = s ^ (s >> XS_SHIFT_A);
        s = s ^ (s << XS_SHIFT_B);
        s = s ^ (s >> XS_SHIFT_C);
        gen_m = s;
        return s * KEY_MULT;
    endfunction

    // fold one board word into the running hash, close the board on its last word
    task automatic hash_board_word(input t_board_word w);
        logic [63:0] k_red, k_black, k_tile;
        logic [63:0] ph0, ph1, pl0, pl1;
        int b;
        // seed is picked up only at a board start
        if (word_idx_m == 0) begin
            gen_m = seed_m;
            acc_m = '0;
        end
        for (b = 0; b < 64; b++) begin
            k_red   = draw_key();
            k_black = draw_key();
            k_tile  = draw_key();
            if (w.red[b])   acc_m = acc_m ^ k_red;
            if (w.black[b]) acc_m = acc_m ^ k_black;
            if (w.tile[b])  acc_m = acc_m ^ k_tile;
        end
        word_idx_m++;
        if (word_idx_m == BOARD_WORDS) begin
            ph0 = draw_key();
            ph1 = draw_key();
            pl0 = draw_key();
            pl1 = draw_key();
            acc_m = acc_m ^ (w.side ? pl1 : pl0);
            acc_m = acc_m ^ (w.phase ? ph1 : ph0);
            pending_hashes.push_back(acc_m);
            acc_m = '0;
            word_idx_m = 0;
        end
    endtask

    // input driver: predict on accept, then offer the next word or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                hash_board_word(offered);
            end
            // payload may only move once the current word is gone
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (!quiet && $urandom_range(99) < 25) begin
                    // gaps of varied length so they land anywhere in the bit walk
                    send_gap = $urandom_range(0, 200);
                    i_in_valid <= 1'b0;
                end else if (word_q.size() > 0) begin
                    offered = word_q.pop_front();
                    i_in_valid     <= 1'b1;
                    i_red_word     <= offered.red;
                    i_black_word   <= offered.black;
                    i_tile_word    <= offered.tile;
                    i_side_to_move <= offered.side;
                    i_move_phase   <= offered.phase;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result-side stall: short random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (!hold_done && hashes_seen >= 10 && word_q.size() > 60) begin
            // long enough for the output register and the next board to back up
            hold_left = 4000;
            hold_done = 1'b1;
            i_out_stall <= 1'b1;
        end else if (stall_len > 0) begin
            stall_len--;
            i_out_stall <= 1'b1;
        end else if (!quiet && $urandom_range(99) < 4) begin
            stall_len = $urandom_range(0, 6);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // result monitor: each accepted hash against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            hashes_seen++;
            if (pending_hashes.size() == 0) begin
                $error("board_hash with nothing expected: expected none, got %h",
                       o_board_hash);
                mismatches++;
            end else begin
                want = pending_hashes.pop_front();
                if (o_board_hash !== want) begin
                    $error("board_hash mismatch: expected %h, got %h",
                           want, o_board_hash);
                    mismatches++;
                end
            end
        end
    end

    // random occupancy pattern, biased toward extremes and sparse words
    function automatic logic [63:0] rand_bits();
        logic [63:0] v;
        case ($urandom_range(9))
            0: begin
                v = '0;
            end
            1: begin
                v = '1;
            end
            2: begin
                v = 64'd1 << $urandom_range(63);
            end
            3: begin
                v = ~(64'd1 << $urandom_range(63));
            end
            4, 5: begin
                v = {$urandom, $urandom} & {$urandom, $urandom};
            end
            default: begin
                v = {$urandom, $urandom};
            end
        endcase
        return v;
    endfunction

    task automatic push_word(input logic [63:0] r, input logic [63:0] b,
                             input logic [63:0] t, input logic s, input logic p);
        t_board_word w;
        w.red   = r;
        w.black = b;
        w.tile  = t;
        w.side  = s;
        w.phase = p;
        word_q.push_back(w);
    endtask

    // wait until every word is taken, every hash seen, and the bit walk is over
    task automatic drain_block();
        while (word_q.size() != 0 || i_in_valid || pending_hashes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_seed(input logic [63:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        seed_m = v;
        @(posedge i_clk);
    endtask

    // stimulus: directed boards, then random phases under changing seeds
    initial begin : stimulus
        logic [63:0] seed_list [8];
        logic [63:0] pat;
        int i;
        int ph;
        int n;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty board, red to move, piece phase
        for (i = 0; i < BOARD_WORDS; i++) begin
            push_word('0, '0, '0, 1'b0, 1'b0);
        end
        // every bit set, black to move, tile phase
        for (i = 0; i < BOARD_WORDS; i++) begin
            push_word('1, '1, '1, 1'b1, 1'b1);
        end
        // alternating colors and a walking tile bit
        for (i = 0; i < BOARD_WORDS; i++) begin
            pat = (i % 2) ? 64'hAAAA_AAAA_AAAA_AAAA : 64'h5555_5555_5555_5555;
            push_word(pat, ~pat, 64'd1 << (i * 9), 1'b0, 1'b1);
        end
        // half a board, finished only after the seed changes
        push_word(64'h8000_0000_0000_0000, 64'd1, '1, 1'b1, 1'b0);
        push_word(64'd1, 64'h8000_0000_0000_0000, '0, 1'b0, 1'b1);
        push_word(64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF, 64'hF0F0_F0F0_0F0F_0F0F,
                  1'b1, 1'b1);
        drain_block();

        seed_list[0] = '0;
        seed_list[1] = '1;
        seed_list[2] = 64'd1;
        seed_list[3] = 64'h8000_0000_0000_0000;
        seed_list[4] = {$urandom, $urandom};
        seed_list[5] = KEY_SEED_RST;
        seed_list[6] = {$urandom, $urandom};
        seed_list[7] = {$urandom, $urandom};

        // phase lengths are not multiples of the board, so seeds change mid-board
        for (ph = 0; ph < 8; ph++) begin
            write_seed(seed_list[ph]);
            n = $urandom_range(180, 240);
            for (i = 0; i < n; i++) begin
                push_word(rand_bits(), rand_bits(), rand_bits(),
                          1'($urandom_range(1)), 1'($urandom_range(1)));
            end
            drain_block();
        end

        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #24000000;
        $display("FAIL");
        $finish;
    end

endmodule

>>> zobrist_board_hasher.f
rtl/core/zbh_pkg.sv
rtl/core/zbh_ctrl.sv
rtl/core/zbh_datapath.sv
rtl/core/zobrist_board_hasher.sv
rtl/core/zbh_checker.sv
dv/tb_zobrist_board_hasher.sv
